[hdl/sfpd_pkg.sv]
// sfpd_pkg: constants, types and membership helpers of the fuzzy PD controller.
// No dependencies.
package sfpd_pkg;

  localparam int FracBits   = 14;
  localparam int RecipShift = 16;
  localparam int InW        = 16;
  localparam int DriveW     = 15;
  localparam int MuW        = FracBits + 1;
  localparam int SbW        = MuW + 3;
  localparam int KW         = FracBits + 1;
  localparam int SyW        = MuW + KW + 4;
  localparam int MagW       = SyW - 1;
  localparam int NumW       = MagW + 2;
  localparam int DenW       = SbW + 1;
  localparam int QW         = NumW;

  localparam logic [MuW-1:0] One = MuW'(1 << FracBits);

  localparam longint K0001 = ((longint'(1) <<< FracBits) + 500) / 1000;
  localparam longint K011  = ((longint'(11) <<< FracBits) + 50) / 100;
  localparam longint K017  = ((longint'(17) <<< FracBits) + 50) / 100;
  localparam longint K022  = ((longint'(22) <<< FracBits) + 50) / 100;
  localparam longint K04   = ((longint'(4) <<< FracBits) + 5) / 10;
  localparam longint K08   = ((longint'(8) <<< FracBits) + 5) / 10;
  localparam longint K095  = ((longint'(95) <<< FracBits) + 50) / 100;
  localparam longint LOne  = longint'(1) <<< FracBits;
  localparam longint LTwo  = longint'(2) <<< FracBits;

  // Slope reciprocals, round(2^(FracBits+RecipShift) / width).
  localparam longint RcpNum = longint'(1) <<< (FracBits + RecipShift);
  localparam longint WShd   = K022 - K017;
  localparam longint WNsL   = K022 - K011;
  localparam longint WNsR   = K0001 + K011;
  localparam longint WPsL   = K011 - K0001;
  localparam longint RcpOne = (RcpNum + LOne / 2) / LOne;
  localparam longint RcpShd = (RcpNum + WShd / 2) / WShd;
  localparam longint RcpNsL = (RcpNum + WNsL / 2) / WNsL;
  localparam longint RcpNsR = (RcpNum + WNsR / 2) / WNsR;
  localparam longint RcpZe  = (RcpNum + K011 / 2) / K011;
  localparam longint RcpPsL = (RcpNum + WPsL / 2) / WPsL;
  localparam longint RcpPsR = RcpNsL;
  localparam longint RcpRz  = (RcpNum + K04 / 2) / K04;

  localparam int RegW = InW + 2;
  typedef logic signed [RegW-1:0] wide_t;
  typedef logic [MuW-1:0] mu_t;

  // Ramp term: position diff on a slope, scaled by its constant reciprocal, clamped.
  function automatic mu_t ramp(input wide_t diff, input longint recip);
    longint prod;
    prod = (longint'(diff) * recip + (longint'(1) <<< (RecipShift - 1))) >>> RecipShift;
    if (prod > LOne) ramp = One;
    else ramp = mu_t'(prod);
  endfunction

  function automatic mu_t tri_mu(input wide_t x, input longint a, input longint b,
                                 input longint c, input longint rl, input longint rr);
    if (longint'(x) < a) tri_mu = '0;
    else if (longint'(x) <= b) tri_mu = ramp(wide_t'(longint'(x) - a), rl);
    else if (longint'(x) <= c) tri_mu = ramp(wide_t'(c - longint'(x)), rr);
    else tri_mu = '0;
  endfunction

  function automatic mu_t trap_mu(input wide_t x, input longint a, input longint b,
                                  input longint c, input longint d,
                                  input longint rl, input longint rr);
    if (longint'(x) < a) trap_mu = '0;
    else if (longint'(x) <= b) trap_mu = ramp(wide_t'(longint'(x) - a), rl);
    else if (longint'(x) <= c) trap_mu = One;
    else if (longint'(x) <= d) trap_mu = ramp(wide_t'(d - longint'(x)), rr);
    else trap_mu = '0;
  endfunction

  function automatic mu_t mn(input mu_t a, input mu_t b);
    mn = (a < b) ? a : b;
  endfunction

  function automatic mu_t mx(input mu_t a, input mu_t b);
    mx = (a > b) ? a : b;
  endfunction

endpackage

[hdl/sfpd_if.sv]
// sfpd_if: valid/ready channel interfaces of the fuzzy PD controller.
// Depends on sfpd_pkg.
interface sfpd_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [sfpd_pkg::InW-1:0] error;
  logic signed [sfpd_pkg::InW-1:0] error_rate;
  modport source (output valid, error, error_rate, input ready);
  modport sink   (input valid, error, error_rate, output ready);
endinterface

interface sfpd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sfpd_pkg::DriveW-1:0] drive;
  logic                              no_rule_fired;
  modport source (output valid, drive, no_rule_fired, input ready);
  modport sink   (input valid, drive, no_rule_fired, output ready);
endinterface

[hdl/sfpd_div.sv]
// sfpd_div: pipelined restoring divider, one quotient bit per stage.
// Depends on sfpd_pkg. Moves along when adv is high.
module sfpd_div (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [sfpd_pkg::NumW-1:0]    num,
  input  logic [sfpd_pkg::DenW-1:0]    den,
  input  logic                         neg_in,
  input  logic                         zero_in,
  output logic [sfpd_pkg::QW-1:0]      quo,
  output logic                         neg_out,
  output logic                         zero_out
);
  import sfpd_pkg::*;
  localparam int N  = NumW;
  localparam int RW = DenW + 1;

  logic [RW-1:0]   rem_r [N+1];
  logic [N-1:0]    q_r   [N+1];
  logic [DenW-1:0] den_r [N+1];
  logic [N:0]      neg_r;
  logic [N:0]      zero_r;

  always_comb begin
    rem_r[0] = '0;
    q_r[0]   = num;
    den_r[0] = den;
    neg_r[0] = neg_in;
    zero_r[0] = zero_in;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] sh;
    logic [RW-1:0] diff;
    logic          ge;
    always_comb begin
      sh   = {rem_r[i][RW-2:0], q_r[i][N-1]};
      diff = sh - RW'(den_r[i]);
      ge   = sh >= RW'(den_r[i]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i+1]  <= ge ? diff : sh;
        q_r[i+1]    <= {q_r[i][N-2:0], ge};
        den_r[i+1]  <= den_r[i];
        neg_r[i+1]  <= neg_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  assign quo      = q_r[N];
  assign neg_out  = neg_r[N];
  assign zero_out = zero_r[N];
endmodule

[hdl/sugeno_fuzzy_pd_controller.sv]
// sugeno_fuzzy_pd_controller: 5x3 rule Sugeno fuzzy PD controller, top level.
// Depends on sfpd_pkg, sfpd_if and sfpd_div.
//
//  channel | dir | fields                     | handshake
//  in      | in  | error, error_rate (s16)    | in.valid / in.ready
//  out     | out | drive (s15), no_rule_fired | out.valid / out.ready
//
// One transfer per cycle sustained while the output is not stalled. Stages:
// membership, rule firing, sums, sign/magnitude, then one stage per quotient
// bit of the divider, then sign and saturation into the output register.
// Reset clears the valid bits only. A stall freezes the whole pipe; the
// input is ready whenever the output register is empty or being taken.
module sugeno_fuzzy_pd_controller (
  input  logic           clk,
  input  logic           rst_n,
  sfpd_in_if.sink        in_ch,
  sfpd_out_if.source     out_ch
);
  import sfpd_pkg::*;

  localparam int DivLat = NumW;
  localparam int NStg   = 4 + DivLat;

  logic adv;
  logic [NStg-1:0] vld_r;
  logic            out_vld_r;

  // The pipe advances whenever the output slot is free or is taken now.
  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = adv;

  // Stage 1: membership degrees.
  mu_t e_mu_r [5];
  mu_t r_mu_r [3];
  wide_t ex, rx;
  assign ex = wide_t'(in_ch.error);
  assign rx = wide_t'(in_ch.error_rate);

  always_ff @(posedge clk) begin
    if (adv) begin
      e_mu_r[0] <= trap_mu(ex, -LTwo, -LOne, -K022, -K017, RcpOne, RcpShd);
      e_mu_r[1] <= tri_mu(ex, -K022, -K011, K0001, RcpNsL, RcpNsR);
      e_mu_r[2] <= tri_mu(ex, -K011, 0, K011, RcpZe, RcpZe);
      e_mu_r[3] <= tri_mu(ex, K0001, K011, K022, RcpPsL, RcpPsR);
      e_mu_r[4] <= trap_mu(ex, K017, K022, LOne, LTwo, RcpShd, RcpOne);
      r_mu_r[0] <= trap_mu(rx, -LTwo, -LOne, -K022, -K017, RcpOne, RcpShd);
      r_mu_r[1] <= tri_mu(rx, -K04, 0, K04, RcpRz, RcpRz);
      r_mu_r[2] <= trap_mu(rx, K017, K022, LOne, LTwo, RcpShd, RcpOne);
    end
  end

  // Stage 2: min rules, max merge into seven output sets.
  mu_t s_r [7];
  always_ff @(posedge clk) begin
    if (adv) begin
      s_r[0] <= mn(e_mu_r[0], r_mu_r[0]);
      s_r[1] <= mx(mn(e_mu_r[0], r_mu_r[1]), mn(e_mu_r[1], r_mu_r[0]));
      s_r[2] <= mx(mx(mn(e_mu_r[0], r_mu_r[2]), mn(e_mu_r[1], r_mu_r[1])),
                   mn(e_mu_r[2], r_mu_r[0]));
      s_r[3] <= mx(mx(mn(e_mu_r[1], r_mu_r[2]), mn(e_mu_r[2], r_mu_r[1])),
                   mn(e_mu_r[3], r_mu_r[0]));
      s_r[4] <= mx(mx(mn(e_mu_r[2], r_mu_r[2]), mn(e_mu_r[3], r_mu_r[1])),
                   mn(e_mu_r[4], r_mu_r[0]));
      s_r[5] <= mx(mn(e_mu_r[3], r_mu_r[2]), mn(e_mu_r[4], r_mu_r[1]));
      s_r[6] <= mn(e_mu_r[4], r_mu_r[2]);
    end
  end

  // Stage 3: strength sum and weighted sum (constant multiplies).
  localparam logic [KW-1:0] C095 = KW'(K095);
  localparam logic [KW-1:0] C08  = KW'(K08);
  localparam logic [KW-1:0] C04  = KW'(K04);
  logic [SbW-1:0]        sb_r;
  logic signed [SyW-1:0] sy_r;
  logic signed [SyW-1:0] pos_s, neg_s;
  always_comb begin
    pos_s = SyW'(C095) * SyW'(s_r[6]) + SyW'(C08) * SyW'(s_r[5])
          + SyW'(C04) * SyW'(s_r[4]);
    neg_s = SyW'(C095) * SyW'(s_r[0]) + SyW'(C08) * SyW'(s_r[1])
          + SyW'(C04) * SyW'(s_r[2]);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r <= SbW'(s_r[0]) + SbW'(s_r[1]) + SbW'(s_r[2]) + SbW'(s_r[3])
            + SbW'(s_r[4]) + SbW'(s_r[5]) + SbW'(s_r[6]);
      sy_r <= pos_s - neg_s;
    end
  end

  // Stage 4: sign/magnitude, build 2*mag + sb over 2*sb.
  logic [NumW-1:0] num_r;
  logic [DenW-1:0] den_r;
  logic            neg_r, zero_r;
  logic [MagW-1:0] mag;
  assign mag = sy_r[SyW-1] ? MagW'(-sy_r) : MagW'(sy_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      num_r  <= {1'b0, mag, 1'b0} + NumW'(sb_r);
      den_r  <= (sb_r == '0) ? DenW'(1) : {sb_r, 1'b0};
      neg_r  <= sy_r[SyW-1];
      zero_r <= (sb_r == '0);
    end
  end

  logic [QW-1:0] quo;
  logic          q_neg, q_zero;
  sfpd_div u_div (
    .clk(clk), .adv(adv), .num(num_r), .den(den_r), .neg_in(neg_r),
    .zero_in(zero_r), .quo(quo), .neg_out(q_neg), .zero_out(q_zero)
  );

  // Final stage: apply sign, saturate, hold for the consumer.
  localparam logic [QW-1:0] PosMax = QW'(16383);
  localparam logic [QW-1:0] NegMax = QW'(16384);
  logic signed [DriveW-1:0] drive_nxt;
  always_comb begin
    if (q_zero) drive_nxt = '0;
    else if (q_neg) drive_nxt = (quo > NegMax) ? DriveW'(-16384) : DriveW'(-quo);
    else drive_nxt = (quo > PosMax) ? DriveW'(16383) : DriveW'(quo);
  end

  logic signed [DriveW-1:0] drive_r;
  logic                     nrf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[NStg-2:0], in_ch.valid};
      out_vld_r <= vld_r[NStg-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      drive_r <= drive_nxt;
      nrf_r   <= q_zero;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.drive         = drive_r;
  assign out_ch.no_rule_fired = nrf_r;

`ifndef SYNTHESIS
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && nrf_r |-> drive_r == '0) else $error("flag without zero drive");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(drive_r))
    else $error("stalled result lost");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready) else $error("empty output yet not ready");
`endif
endmodule
